@@ sv/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam int unsigned DefWidth = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_CMP = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM,
        S_RDIV, S_PREP, S_GCD, S_QN, S_QD, S_CHK, S_DONE
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dvd;
        logic [63:0] dvs;
    } t_div_req;

    // divider response
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ sv/rau_div.sv @@
// shared restoring divider, one quotient bit per cycle, unsigned 64 bit
`default_nettype none
module rau_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp      o_rsp
);
    import rau_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_dvs, n_dvs;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_trial;

    // one shift and subtract step
    always_comb begin
        w_trial = {r_rem, r_quo[63]} - {1'b0, r_dvs};
        n_quo = r_quo;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo = i_req.dvd;
            n_rem = '0;
            n_dvs = i_req.dvs;
            n_cnt = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[64]) begin
                n_rem = {r_rem[62:0], r_quo[63]};
                n_quo = {r_quo[62:0], 1'b0};
            end else begin
                n_rem = w_trial[63:0];
                n_quo = {r_quo[62:0], 1'b1};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

@@ sv/rational_arithmetic_unit.sv @@
// top level: sequencer, one multiplier and the shared divider
//
// Rational arithmetic on two operands num/den, opcode in the lowest tdata bits.
// Input beat on s_axis (tdata: opcode, a_num, a_den, b_num, b_den from bit 0),
// result beat on m_axis (tdata: res_num, res_den, status, order from bit 0).
// One item at a time: s_axis_tready is high only while the unit is idle.
// Steps: three products on one 33x33 signed multiplier, then a remainder
// division for the remainder opcode, a Euclid gcd where each step is one
// division, then two divisions for the reduction; every division runs on
// the one shared divider. Compare and undefined opcodes skip the divisions
// and go from the sum step straight to done.
// Reset clears the sequencer and the output valid; no clearing pass.
// When the receiver stalls the result holds in the output register and the
// unit does not take a new beat until the result is taken.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // opcode, a_num, a_den, b_num, b_den, zero pad
    input  wire logic [135:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // res_num, res_den, status, order, zero pad
    output logic [71:0]        m_axis_tdata
);
    import rau_pkg::*;

    localparam logic [63:0] Lim = (64'd1 << (WIDTH - 1)) - 64'd1;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic signed [31:0] r_an, r_bn;
    logic [30:0] r_ad, r_bd;
    // product terms
    logic signed [63:0] r_p0, r_p1, r_den, r_num;
    logic signed [63:0] n_p0, n_p1, n_den, n_num;
    logic [63:0] r_y, n_y;
    logic [63:0] r_un, r_ud, n_un, n_ud;
    logic r_neg, n_neg;
    logic [31:0] r_res_num, n_res_num;
    logic [30:0] r_res_den, n_res_den;
    logic [1:0]  r_status, n_status, r_order, n_order;
    logic r_ovalid, n_ovalid;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    t_div_req w_req;
    t_div_rsp w_rsp;

    // shared divider
    rau_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        f_mag = v[63] ? (64'd0 - v) : v;
    endfunction

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MUL0: begin
                w_ma = 33'(r_an);
                w_mb = (r_op == OP_MUL) ? 33'(r_bn) : {2'b00, r_bd};
            end
            S_MUL1: begin
                w_ma = 33'(r_bn);
                w_mb = {2'b00, r_ad};
            end
            S_MUL2: begin
                w_ma = {2'b00, r_ad};
                w_mb = (r_op == OP_DIV) ? 33'(r_bn) : {2'b00, r_bd};
            end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM: begin
                if (r_op == OP_CMP || !(r_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM}))
                    n_state = S_DONE;
                else if (r_op == OP_REM)
                    n_state = (r_p1 == 64'sd0) ? S_DONE : S_RDIV;
                else
                    n_state = S_PREP;
            end
            S_RDIV: if (w_rsp.done) n_state = S_PREP;
            S_PREP: n_state = (r_den == 64'sd0 || r_num == 64'sd0) ? S_DONE : S_GCD;
            S_GCD: if (w_rsp.done && w_rsp.rem == 64'd0) n_state = S_QN;
            S_QN: if (w_rsp.done) n_state = S_QD;
            S_QD: if (w_rsp.done) n_state = S_CHK;
            S_CHK: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_ovalid && r_state == S_DONE) n_state = S_DONE;
    end

    // datapath and divider control
    always_comb begin
        n_op = r_op;
        n_p0 = r_p0;
        n_p1 = r_p1;
        n_den = r_den;
        n_num = r_num;
        n_y = r_y;
        n_un = r_un;
        n_ud = r_ud;
        n_neg = r_neg;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_status = r_status;
        n_order = r_order;
        n_ovalid = r_ovalid;
        w_req.start = 1'b0;
        w_req.dvd = '0;
        w_req.dvs = '0;
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                n_op = t_op'(s_axis_tdata[2:0]);
                n_res_num = '0;
                n_res_den = '0;
                n_status = ST_OK;
                n_order = ORD_LT;
            end
            S_MUL0: n_p0 = w_prod[63:0];
            S_MUL1: n_p1 = w_prod[63:0];
            S_MUL2: n_den = w_prod[63:0];
            S_SUM: begin
                case (r_op)
                    OP_ADD: n_num = r_p0 + r_p1;
                    OP_SUB: n_num = r_p0 - r_p1;
                    OP_CMP: begin
                        n_num = r_p0 - r_p1;
                        n_order = (r_p0 < r_p1) ? ORD_LT
                                : ((r_p0 == r_p1) ? ORD_EQ : ORD_GT);
                    end
                    OP_REM: begin
                        if (r_p1 == 64'sd0) n_status = ST_ZDEN;
                        w_req.start = (r_p1 != 64'sd0);
                        w_req.dvd = f_mag(r_p0);
                        w_req.dvs = f_mag(r_p1);
                    end
                    default: n_num = r_p0;
                endcase
            end
            S_RDIV: if (w_rsp.done)
                n_num = r_p0[63] ? (64'sd0 - w_rsp.rem) : w_rsp.rem;
            S_PREP: begin
                n_neg = r_num[63] ^ r_den[63];
                n_un = f_mag(r_num);
                n_ud = f_mag(r_den);
                n_y = f_mag(r_den);
                if (r_den == 64'sd0) n_status = ST_ZDEN;
                else if (r_num == 64'sd0) n_res_den = 31'd1;
                else begin
                    w_req.start = 1'b1;
                    w_req.dvd = f_mag(r_num);
                    w_req.dvs = f_mag(r_den);
                end
            end
            S_GCD: if (w_rsp.done) begin
                // euclid step: x, y <- y, x mod y
                w_req.start = 1'b1;
                if (w_rsp.rem == 64'd0) begin
                    w_req.dvd = r_un;
                    w_req.dvs = r_y;
                end else begin
                    n_y = w_rsp.rem;
                    w_req.dvd = r_y;
                    w_req.dvs = w_rsp.rem;
                end
            end
            S_QN: if (w_rsp.done) begin
                n_un = w_rsp.quo;
                w_req.start = 1'b1;
                w_req.dvd = r_ud;
                w_req.dvs = r_y;
            end
            S_QD: if (w_rsp.done) n_ud = w_rsp.quo;
            S_CHK: begin
                if (r_ud > Lim || (r_neg ? (r_un > Lim + 64'd1) : (r_un > Lim)))
                    n_status = ST_OVF;
                else begin
                    n_res_num = r_neg ? 32'(64'd0 - r_un) : r_un[31:0];
                    n_res_den = r_ud[30:0];
                end
            end
            S_DONE: if (!r_ovalid) n_ovalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_an <= s_axis_tdata[34:3];
            r_ad <= s_axis_tdata[65:35];
            r_bn <= s_axis_tdata[97:66];
            r_bd <= s_axis_tdata[128:98];
        end
        r_op <= n_op;
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_den <= n_den;
        r_num <= n_num;
        r_y <= n_y;
        r_un <= n_un;
        r_ud <= n_ud;
        r_neg <= n_neg;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_status <= n_status;
        r_order <= n_order;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_order, r_status, r_res_den, r_res_num};

`ifndef SYNTHESIS
    // the divider is never restarted while a division runs
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy) else $error("divider restarted while busy");
    // a shown result never comes with a free input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken over pending result");
    // an ok non-compare result has a nonzero denominator
    a_den_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == ST_OK && r_op != OP_CMP
         && (r_op == OP_ADD || r_op == OP_SUB || r_op == OP_MUL
             || r_op == OP_DIV || r_op == OP_REM)) |-> (r_res_den != '0))
        else $error("zero denominator with ok status");
`endif
endmodule
`default_nettype wire
